// ===== rtl/pcpbs_pkg.sv =====
package pcpbs_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int CFG_MS_W       = 16;
  localparam int RETRY_CNT_W    = 3;
  localparam int APB_DATA_W     = 32;
  localparam int APB_ADDR_W     = 4;

  localparam logic [CFG_MS_W-1:0]    PRESS_MS_RST    = 16'd200;
  localparam logic [CFG_MS_W-1:0]    RETRY_MS_RST    = 16'd10000;
  localparam logic [RETRY_CNT_W-1:0] MAX_RETRIES_RST = 3'd2;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] REG_PRESS_MS    = 2'd0;
  localparam logic [1:0] REG_RETRY_MS    = 2'd1;
  localparam logic [1:0] REG_MAX_RETRIES = 2'd2;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_SHUTDOWN,
    MODE_STARTUP
  } mode_e;

endpackage

// ===== rtl/pc_power_button_sequencer.sv =====
// a result is registered and valid in the cycle after its item is accepted
// throughput: one item per cycle; a new item is taken while the result
//   register is empty or being drained in the same cycle
// reset: rst_ni clears the sequence, the press and the result valid at once,
//   and loads press_ms 200, retry_ms 10000, max_retries 2
module pc_power_button_sequencer #(
  parameter int TIMER_BITS = pcpbs_pkg::TIMER_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                pc_powered_i,
  input  logic                                cmd_valid_i,
  input  logic                                cmd_on_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                button_drive_o,
  output logic                                reported_on_o,
  output logic                                gave_up_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pcpbs_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [pcpbs_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [pcpbs_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);

  localparam int CmpW = (TIMER_BITS > pcpbs_pkg::CFG_MS_W) ? TIMER_BITS : pcpbs_pkg::CFG_MS_W;
  localparam logic [TIMER_BITS-1:0] TMax = {TIMER_BITS{1'b1}};

  // configuration registers
  logic [pcpbs_pkg::CFG_MS_W-1:0]    press_ms_q, retry_ms_q;
  logic [pcpbs_pkg::RETRY_CNT_W-1:0] max_retries_q;
  logic                              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      press_ms_q    <= pcpbs_pkg::PRESS_MS_RST;
      retry_ms_q    <= pcpbs_pkg::RETRY_MS_RST;
      max_retries_q <= pcpbs_pkg::MAX_RETRIES_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        pcpbs_pkg::REG_PRESS_MS:    press_ms_q    <= pwdata[pcpbs_pkg::CFG_MS_W-1:0];
        pcpbs_pkg::REG_RETRY_MS:    retry_ms_q    <= pwdata[pcpbs_pkg::CFG_MS_W-1:0];
        pcpbs_pkg::REG_MAX_RETRIES: max_retries_q <= pwdata[pcpbs_pkg::RETRY_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      pcpbs_pkg::REG_PRESS_MS:    prdata = pcpbs_pkg::APB_DATA_W'(press_ms_q);
      pcpbs_pkg::REG_RETRY_MS:    prdata = pcpbs_pkg::APB_DATA_W'(retry_ms_q);
      pcpbs_pkg::REG_MAX_RETRIES: prdata = pcpbs_pkg::APB_DATA_W'(max_retries_q);
      default:                    prdata = '0;
    endcase
  end

  // handshake
  logic in_acc;
  logic out_valid_q, out_valid_d;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_acc      = in_valid_i & ~in_stall_o;
  assign out_valid_d = in_acc | (out_valid_q & out_stall_i);

  // sequence state
  pcpbs_pkg::mode_e                  mode_q, mode_d;
  logic [pcpbs_pkg::RETRY_CNT_W-1:0] retry_cnt_q, retry_cnt_d;
  logic [TIMER_BITS-1:0]             seq_tmr_q, seq_tmr_d;
  logic                              press_act_q, press_act_d;
  logic [TIMER_BITS-1:0]             press_tmr_q, press_tmr_d;

  logic press_start;
  logic gave_w, drive_w, rep_w;

  // request, then sequence check
  always_comb begin
    pcpbs_pkg::mode_e mode_r;
    logic             reached;
    logic             expired;
    mode_r      = mode_q;
    retry_cnt_d = retry_cnt_q;
    seq_tmr_d   = seq_tmr_q;
    press_start = 1'b0;
    gave_w      = 1'b0;

    if (cmd_valid_i) begin
      if (cmd_on_i && !pc_powered_i && mode_q != pcpbs_pkg::MODE_STARTUP) begin
        mode_r      = pcpbs_pkg::MODE_STARTUP;
        retry_cnt_d = '0;
        seq_tmr_d   = '0;
        press_start = 1'b1;
      end else if (!cmd_on_i && pc_powered_i && mode_q != pcpbs_pkg::MODE_SHUTDOWN) begin
        mode_r      = pcpbs_pkg::MODE_SHUTDOWN;
        retry_cnt_d = '0;
        seq_tmr_d   = '0;
        press_start = 1'b1;
      end
    end

    mode_d  = mode_r;
    reached = (mode_r == pcpbs_pkg::MODE_SHUTDOWN) ? !pc_powered_i : pc_powered_i;
    expired = (CmpW'(seq_tmr_d) >= CmpW'(retry_ms_q)) || (seq_tmr_d == TMax);

    if (mode_r != pcpbs_pkg::MODE_IDLE) begin
      if (reached) begin
        mode_d      = pcpbs_pkg::MODE_IDLE;
        retry_cnt_d = '0;
        seq_tmr_d   = '0;
      end else if (expired) begin
        if (retry_cnt_d < max_retries_q) begin
          retry_cnt_d = pcpbs_pkg::RETRY_CNT_W'(retry_cnt_d + 1'b1);
          seq_tmr_d   = '0;
          press_start = 1'b1;
        end else begin
          mode_d      = pcpbs_pkg::MODE_IDLE;
          retry_cnt_d = '0;
          seq_tmr_d   = '0;
          gave_w      = 1'b1;
        end
      end else begin
        seq_tmr_d = seq_tmr_d + 1'b1;
      end
    end
  end

  // button drive
  always_comb begin
    logic                  act;
    logic [TIMER_BITS-1:0] tmr;
    act = press_start | press_act_q;
    tmr = press_start ? '0 : press_tmr_q;
    drive_w = act && (CmpW'(tmr) < CmpW'(press_ms_q));
    if (drive_w) begin
      press_act_d = 1'b1;
      press_tmr_d = (tmr == TMax) ? tmr : tmr + 1'b1;
    end else begin
      press_act_d = 1'b0;
      press_tmr_d = tmr;
    end
  end

  // reported state
  always_comb begin
    case (mode_d)
      pcpbs_pkg::MODE_STARTUP:  rep_w = 1'b1;
      pcpbs_pkg::MODE_SHUTDOWN: rep_w = 1'b0;
      default:                  rep_w = pc_powered_i;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= pcpbs_pkg::MODE_IDLE;
      retry_cnt_q <= '0;
      seq_tmr_q   <= '0;
      press_act_q <= 1'b0;
      press_tmr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_acc) begin
        mode_q      <= mode_d;
        retry_cnt_q <= retry_cnt_d;
        seq_tmr_q   <= seq_tmr_d;
        press_act_q <= press_act_d;
        press_tmr_q <= press_tmr_d;
      end
    end
  end

  logic drive_q, rep_q, gave_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      drive_q <= drive_w;
      rep_q   <= rep_w;
      gave_q  <= gave_w;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign button_drive_o = drive_q;
  assign reported_on_o  = rep_q;
  assign gave_up_o      = gave_q;

endmodule

// ===== rtl/pcpbs_checker.sv =====
module pcpbs_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic                             button_drive_o,
  input logic                             reported_on_o,
  input logic                             gave_up_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(button_drive_o)
      && $stable(reported_on_o) && $stable(gave_up_o))
    else $error("stalled result changed");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held result");

  // every accepted item yields a result on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  // no result without an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || !out_stall_i) && !in_valid_i |=> !out_valid_o)
    else $error("result appeared without an item");

endmodule

bind pc_power_button_sequencer pcpbs_checker u_pcpbs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .button_drive_o (button_drive_o),
  .reported_on_o  (reported_on_o),
  .gave_up_o      (gave_up_o)
);

// ===== sim/pc_power_button_sequencer_tb.sv =====
`timescale 1ns / 1ps

module pc_power_button_sequencer_tb;

  localparam int TW = pcpbs_pkg::TIMER_BITS_DEF;
  localparam logic [TW-1:0] TIMER_MAX = '1;
  localparam int STUCK_LIMIT = 3000;
  localparam int LONG_HOLD_CYCLES = 90;

  typedef struct packed {
    logic powered;
    logic req_valid;
    logic req_on;
  } tick_in_t;

  typedef struct packed {
    logic drive;
    logic report_on;
    logic gave;
  } tick_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  logic pc_powered = 1'b0;
  logic cmd_valid = 1'b0;
  logic cmd_on = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic button_drive;
  logic reported_on;
  logic gave_up;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pcpbs_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [pcpbs_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [pcpbs_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  pc_power_button_sequencer DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .pc_powered_i   (pc_powered),
    .cmd_valid_i    (cmd_valid),
    .cmd_on_i       (cmd_on),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .button_drive_o (button_drive),
    .reported_on_o  (reported_on),
    .gave_up_o      (gave_up),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sequencer copy: configuration and state
  logic [pcpbs_pkg::CFG_MS_W-1:0] cfg_press_ms;
  logic [pcpbs_pkg::CFG_MS_W-1:0] cfg_retry_ms;
  logic [pcpbs_pkg::RETRY_CNT_W-1:0] cfg_max_retries;
  pcpbs_pkg::mode_e seq_mode;
  logic [pcpbs_pkg::RETRY_CNT_W-1:0] presses_retried;
  logic [TW-1:0] since_press;
  logic pressing;
  logic [TW-1:0] held_ticks;

  tick_in_t pending_ticks[$];
  tick_out_t expected_ticks[$];
  int ticks_in_flight = 0;
  int results_seen = 0;
  int error_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_left = 0;
  int stuck_cycles = 0;
  bit long_hold_done = 1'b0;
  bit no_idling = 1'b0;
  logic pc_level = 1'b0;

  task automatic flag_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic start_press();
    pressing = 1'b1;
    held_ticks = '0;
  endtask

  task automatic predict_tick(input logic powered, input logic req_valid, input logic req_on);
    tick_out_t r;
    logic reached;
    r = '0;
    if (req_valid) begin
      if (req_on && !powered && seq_mode != pcpbs_pkg::MODE_STARTUP) begin
        seq_mode = pcpbs_pkg::MODE_STARTUP;
        presses_retried = '0;
        since_press = '0;
        start_press();
      end else if (!req_on && powered && seq_mode != pcpbs_pkg::MODE_SHUTDOWN) begin
        seq_mode = pcpbs_pkg::MODE_SHUTDOWN;
        presses_retried = '0;
        since_press = '0;
        start_press();
      end
    end
    if (seq_mode != pcpbs_pkg::MODE_IDLE) begin
      reached = (seq_mode == pcpbs_pkg::MODE_SHUTDOWN) ? !powered : powered;
      if (reached) begin
        seq_mode = pcpbs_pkg::MODE_IDLE;
        presses_retried = '0;
        since_press = '0;
      end else if (since_press >= cfg_retry_ms || since_press == TIMER_MAX) begin
        if (presses_retried < cfg_max_retries) begin
          presses_retried = presses_retried + 1'b1;
          since_press = '0;
          start_press();
        end else begin
          seq_mode = pcpbs_pkg::MODE_IDLE;
          presses_retried = '0;
          since_press = '0;
          r.gave = 1'b1;
        end
      end else begin
        since_press = since_press + 1'b1;
      end
    end
    if (pressing && held_ticks < cfg_press_ms) begin
      r.drive = 1'b1;
      if (held_ticks != TIMER_MAX) held_ticks = held_ticks + 1'b1;
    end else begin
      pressing = 1'b0;
    end
    if (seq_mode == pcpbs_pkg::MODE_STARTUP) r.report_on = 1'b1;
    else if (seq_mode == pcpbs_pkg::MODE_SHUTDOWN) r.report_on = 1'b0;
    else r.report_on = powered;
    expected_ticks.push_back(r);
  endtask

  // sender
  always @(posedge clk) begin
    tick_in_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_tick(pc_powered, cmd_valid, cmd_on);
        ticks_in_flight--;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!no_idling && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_ticks.pop_front();
          pc_powered <= nxt.powered;
          cmd_valid <= nxt.req_valid;
          cmd_on <= nxt.req_on;
          in_valid <= 1'b1;
        end
      end
    end
  end

  // receiver and result check
  always @(posedge clk) begin
    tick_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (expected_ticks.size() == 0) begin
          flag_error($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_ticks.pop_front();
          if (button_drive !== want.drive)
            flag_error($sformatf("result %0d: button_drive %b, expected %b",
                                 results_seen, button_drive, want.drive));
          if (reported_on !== want.report_on)
            flag_error($sformatf("result %0d: reported_on %b, expected %b",
                                 results_seen, reported_on, want.report_on));
          if (gave_up !== want.gave)
            flag_error($sformatf("result %0d: gave_up %b, expected %b",
                                 results_seen, gave_up, want.gave));
        end
      end
      // one long hold-off so the output fills and the input backs up
      if (!long_hold_done && results_seen >= 250) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!no_idling && $urandom_range(0, 15) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("timeout: no item moved for %0d cycles", STUCK_LIMIT);
        $display("pc_power_button_sequencer_tb: done, errors");
        $finish;
      end
    end
  end

  task automatic queue_tick(input logic powered, input logic req_valid, input logic req_on);
    tick_in_t t;
    t.powered = powered;
    t.req_valid = req_valid;
    t.req_on = req_on;
    pending_ticks.push_back(t);
    ticks_in_flight++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (ticks_in_flight != 0 || expected_ticks.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [pcpbs_pkg::CFG_MS_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {{(pcpbs_pkg::APB_DATA_W - pcpbs_pkg::CFG_MS_W){1'b0}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      pcpbs_pkg::REG_PRESS_MS:    cfg_press_ms = val;
      pcpbs_pkg::REG_RETRY_MS:    cfg_retry_ms = val;
      pcpbs_pkg::REG_MAX_RETRIES: cfg_max_retries = val[pcpbs_pkg::RETRY_CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_timing(input int press, input int retry, input int retries);
    write_reg(pcpbs_pkg::REG_PRESS_MS, pcpbs_pkg::CFG_MS_W'(press));
    write_reg(pcpbs_pkg::REG_RETRY_MS, pcpbs_pkg::CFG_MS_W'(retry));
    write_reg(pcpbs_pkg::REG_MAX_RETRIES, pcpbs_pkg::CFG_MS_W'(retries));
  endtask

  // mostly request / wait / pc responds (or not), some random noise
  task automatic queue_random_ticks(input int n);
    int made;
    int span;
    int wait_len;
    int k;
    made = 0;
    while (made < n) begin
      if ($urandom_range(0, 4) == 0) begin
        k = $urandom_range(1, 6);
        repeat (k) begin
          pc_level = $urandom_range(0, 1);
          queue_tick(pc_level, $urandom_range(0, 1), $urandom_range(0, 1));
        end
        made += k;
      end else begin
        span = int'(cfg_retry_ms) * (int'(cfg_max_retries) + 2) + 2;
        if (span > 40) span = 40;
        wait_len = $urandom_range(0, span);
        queue_tick(pc_level, 1'b1, !pc_level);
        repeat (wait_len)
          queue_tick(pc_level, $urandom_range(0, 9) == 0, $urandom_range(0, 1));
        if ($urandom_range(0, 3) != 0) pc_level = !pc_level;
        k = $urandom_range(1, 4);
        repeat (k) queue_tick(pc_level, 1'b0, $urandom_range(0, 1));
        made += 1 + wait_len + k;
      end
    end
  endtask

  initial begin
    int phase;
    cfg_press_ms = pcpbs_pkg::PRESS_MS_RST;
    cfg_retry_ms = pcpbs_pkg::RETRY_MS_RST;
    cfg_max_retries = pcpbs_pkg::MAX_RETRIES_RST;
    seq_mode = pcpbs_pkg::MODE_IDLE;
    presses_retried = '0;
    since_press = '0;
    pressing = 1'b0;
    held_ticks = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset timing: start up, pc comes up, shut down, pc goes off
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b1, 1'b0);
    queue_tick(1'b1, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b0);
    wait_drained();

    set_timing(2, 3, 1);
    queue_tick(1'b0, 1'b1, 1'b0);   // off while off is ignored
    queue_tick(1'b0, 1'b0, 1'b1);   // request bit without valid
    queue_tick(1'b0, 1'b1, 1'b1);   // startup, pc never answers
    queue_tick(1'b0, 1'b1, 1'b1);   // redundant on while starting
    repeat (7) queue_tick(1'b0, 1'b0, 1'b0);   // retry press, then give up
    queue_tick(1'b0, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b0, 1'b0);   // pc came up
    queue_tick(1'b1, 1'b1, 1'b1);   // on while on is ignored
    queue_tick(1'b1, 1'b1, 1'b0);   // shutdown
    queue_tick(1'b1, 1'b1, 1'b0);   // redundant off
    queue_tick(1'b0, 1'b1, 1'b1);   // startup cancels the shutdown
    queue_tick(1'b1, 1'b1, 1'b0);   // and shutdown cancels the startup
    queue_tick(1'b0, 1'b0, 1'b0);
    wait_drained();

    pc_level = 1'b0;
    for (phase = 0; phase < 9; phase++) begin
      case (phase)
        0: set_timing(1, 1, 0);
        1: set_timing(65535, 65535, 7);
        2: set_timing(9, 2, 7);   // presses overlap
        default: set_timing($urandom_range(1, 12), $urandom_range(1, 12),
                             $urandom_range(0, 7));
      endcase
      no_idling = (phase == 8);
      queue_random_ticks((phase == 1) ? 60 : 115);
      wait_drained();
    end

    if (expected_ticks.size() != 0)
      flag_error($sformatf("%0d results never arrived", expected_ticks.size()));
    if (error_count == 0) begin
      $display("pc_power_button_sequencer_tb: done, clean");
    end else begin
      $display("pc_power_button_sequencer_tb: done, errors");
    end
    $finish;
  end

endmodule
